// ----- src/mspp_pkg.sv -----
// shared types and constants of the msp request frame parser
package mspp_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int LEN_W = 7;
  localparam int IDX_W = 6;
  localparam int TIME_W = 32;

  localparam logic [7:0] SYM_START = 8'h24;
  localparam logic [7:0] SYM_M = 8'h4D;
  localparam logic [7:0] SYM_ARROW = 8'h3C;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd200000;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_M     = 3'd1,
    ST_ARROW = 3'd2,
    ST_LEN   = 3'd3,
    ST_CMD   = 3'd4,
    ST_DATA  = 3'd5,
    ST_SUM   = 3'd6
  } parse_state_t;

  typedef struct packed {
    parse_state_t      state;
    logic [7:0]        csum;
    logic [LEN_W-1:0]  flen;
    logic [LEN_W-1:0]  pcount;
    logic [7:0]        cmd;
    logic [TIME_W-1:0] ref_time;
  } parser_regs_t;

  typedef struct packed {
    logic              frame_ok;
    logic              frame_bad;
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [IDX_W-1:0]  data_index;
    logic [7:0]        command;
    logic [LEN_W-1:0]  length;
  } parser_result_t;

endpackage

// ----- src/msp_request_frame_parser_unit.sv -----
// msp request frame parser top level: input register, parser state, result register
//
// usage: one received serial byte with its microsecond timestamp enters on the
// s_axis channel per word; every accepted word gives exactly one result word
// on m_axis, in order. tuser flags a payload byte, a good checksum or a bad
// checksum; tdata carries the payload byte, its index, the current command
// and the current length.
// the cfg channel writes the 32-bit timeout; cfg_ready is always high and the
// value takes effect for the next byte that is parsed.
// path: the accepted input word is held in the input register, then the parser
// step writes its result into the result register.
// throughput: one word per cycle while m_axis does not stall; the parser step is a
// single registered pass bounded by the 32-bit timestamp subtract and compare.
// reset: parser hunts for the start symbol, timeout returns to 200000, both
// pipeline registers empty.
// stall: a held result keeps its word; one more input word is taken into the
// input register, then s_axis_tready drops until m_axis_tready returns.
module msp_request_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // rx_byte[7:0], time_us[39:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // data_byte[7:0], data_index[13:8], command[21:14],
                                      // length[28:22], zero[31:29]
  output logic [2:0]  m_axis_tuser,   // frame_ok[0], frame_bad[1], data_valid[2]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic                        in_valid;
  logic [7:0]                  in_byte;
  logic [mspp_pkg::TIME_W-1:0] in_time;
  logic [mspp_pkg::TIME_W-1:0] timeout_us;
  mspp_pkg::parser_regs_t      regs;
  mspp_pkg::parser_regs_t      regs_next;
  mspp_pkg::parser_result_t    res_next;
  mspp_pkg::parser_result_t    res;
  logic                        out_valid;
  logic                        advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_us <= mspp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_us <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_time <= s_axis_tdata[39:8];
    end
  end

  mspp_step u_step (
    .cur        (regs),
    .rx_byte    (in_byte),
    .time_us    (in_time),
    .timeout_us (timeout_us),
    .nxt        (regs_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (advance) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, res.length, res.command, res.data_index, res.data_byte};
  assign m_axis_tuser  = {res.data_valid, res.frame_bad, res.frame_ok};

endmodule

// ----- src/mspp_step.sv -----
// one byte step of the frame parser: next parser registers and the result word
module mspp_step (
  input  mspp_pkg::parser_regs_t          cur,
  input  logic [7:0]                      rx_byte,
  input  logic [mspp_pkg::TIME_W-1:0]     time_us,
  input  logic [mspp_pkg::TIME_W-1:0]     timeout_us,
  output mspp_pkg::parser_regs_t          nxt,
  output mspp_pkg::parser_result_t        res
);

  logic [mspp_pkg::TIME_W-1:0] elapsed;
  logic                        timed_out;
  mspp_pkg::parse_state_t      base_state;
  logic [mspp_pkg::LEN_W-1:0]  pcount_inc;
  logic [7:0]                  csum_xor;

  assign elapsed    = time_us - cur.ref_time;
  assign timed_out  = elapsed > timeout_us;
  assign base_state = timed_out ? mspp_pkg::ST_HUNT : cur.state;
  assign pcount_inc = cur.pcount + mspp_pkg::LEN_W'(1);
  assign csum_xor   = cur.csum ^ rx_byte;

  // next parser registers
  always_comb begin
    nxt = cur;
    nxt.ref_time = timed_out ? time_us : cur.ref_time;
    case (base_state)
      mspp_pkg::ST_M: begin
        nxt.state = (rx_byte == mspp_pkg::SYM_M) ? mspp_pkg::ST_ARROW : mspp_pkg::ST_HUNT;
      end
      mspp_pkg::ST_ARROW: begin
        if (rx_byte == mspp_pkg::SYM_ARROW) begin
          nxt.csum  = 8'd0;
          nxt.flen  = '0;
          nxt.state = mspp_pkg::ST_LEN;
        end else begin
          nxt.state = mspp_pkg::ST_HUNT;
        end
      end
      mspp_pkg::ST_LEN: begin
        if (rx_byte <= 8'(mspp_pkg::MAX_PAYLOAD)) begin
          nxt.flen   = rx_byte[mspp_pkg::LEN_W-1:0];
          nxt.pcount = '0;
          nxt.csum   = csum_xor;
          nxt.state  = mspp_pkg::ST_CMD;
        end else begin
          nxt.state = mspp_pkg::ST_HUNT;
        end
      end
      mspp_pkg::ST_CMD: begin
        nxt.cmd   = rx_byte;
        nxt.csum  = csum_xor;
        nxt.state = (cur.flen == '0) ? mspp_pkg::ST_SUM : mspp_pkg::ST_DATA;
      end
      mspp_pkg::ST_DATA: begin
        nxt.csum   = csum_xor;
        nxt.pcount = pcount_inc;
        if (pcount_inc >= cur.flen) begin
          nxt.state = mspp_pkg::ST_SUM;
        end
      end
      mspp_pkg::ST_SUM: begin
        nxt.state = mspp_pkg::ST_HUNT;
      end
      default: begin
        nxt.state = (rx_byte == mspp_pkg::SYM_START) ? mspp_pkg::ST_M : mspp_pkg::ST_HUNT;
      end
    endcase
  end

  // result word
  always_comb begin
    res            = '0;
    res.command    = nxt.cmd;
    res.length     = nxt.flen;
    case (base_state)
      mspp_pkg::ST_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = rx_byte;
        res.data_index = cur.pcount[mspp_pkg::IDX_W-1:0];
      end
      mspp_pkg::ST_SUM: begin
        res.frame_ok  = (cur.csum == rx_byte);
        res.frame_bad = (cur.csum != rx_byte);
      end
      default: begin
        res.data_valid = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/mspp_checker.sv -----
// port-level checks of the msp request frame parser, bound to the top level
module mspp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  a_ok_bad_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("frame_ok and frame_bad both set");

  a_data_not_sum: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == 2'b00))
    else $error("payload word flagged as checksum");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[13:0] == 14'd0))
    else $error("data fields set without data_valid");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[28:22] <= 7'd64 && m_axis_tdata[31:29] == 3'd0))
    else $error("length out of range or padding set");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result word changed");

endmodule

bind msp_request_frame_parser_unit mspp_checker u_mspp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
